>>> design/sssd_pkg.sv
// Package for the seven-segment scan driver: shared types, register codes,
// glyph table and the constant-divisor digit split. No dependencies.
`default_nettype none

package sssd_pkg;

    localparam int CountW = 16;
    localparam int ValueW = 10;
    localparam int EnableW = 3;
    localparam int SegW = 7;

    localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [ValueW-1:0] VALUE_MAX = 10'd999;
    localparam logic [CountW-1:0] PERIOD_RESET = 16'd5;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_VALUE = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    // digit selects
    localparam logic [EnableW-1:0] SEL_NONE = 3'b000;
    localparam logic [EnableW-1:0] SEL_LEFT = 3'b001;
    localparam logic [EnableW-1:0] SEL_MID = 3'b010;
    localparam logic [EnableW-1:0] SEL_RIGHT = 3'b100;

    // letter glyph codes
    localparam logic [3:0] GLYPH_H = 4'd10;
    localparam logic [3:0] GLYPH_L = 4'd11;
    localparam logic [3:0] GLYPH_I = 4'd12;
    localparam logic [3:0] GLYPH_O = 4'd13;

    // number scan step; the spare code acts as the hundreds step
    typedef enum logic [1:0] {
        PH_HUNDREDS = 2'd0,
        PH_TENS     = 2'd1,
        PH_ONES     = 2'd2,
        PH_SPARE    = 2'd3
    } number_phase_t;

    typedef struct packed {
        logic              display_mode;
        logic [ValueW-1:0] display_value;
        logic [CountW-1:0] scan_period;
    } cfg_t;

    typedef struct packed {
        logic [EnableW-1:0] digit_enable;
        logic [SegW-1:0]    segments_n;
        logic               refreshed;
    } result_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    // active-high pattern, bit0 = a .. bit6 = g
    function automatic logic [SegW-1:0] glyph_bits(input logic [3:0] code);
        logic [SegW-1:0] bits;
        case (code)
            4'd0:    bits = 7'h3F;
            4'd1:    bits = 7'h06;
            4'd2:    bits = 7'h5B;
            4'd3:    bits = 7'h4F;
            4'd4:    bits = 7'h66;
            4'd5:    bits = 7'h6D;
            4'd6:    bits = 7'h7D;
            4'd7:    bits = 7'h27;
            4'd8:    bits = 7'h7F;
            4'd9:    bits = 7'h6F;
            GLYPH_H: bits = 7'h76;
            GLYPH_L: bits = 7'h38;
            GLYPH_I: bits = 7'h30;
            GLYPH_O: bits = 7'h5C;
            default: bits = 7'h3F;
        endcase
        return bits;
    endfunction

    // v in 0..999: /100 as *41>>12, /10 as *205>>11 (exact over these ranges)
    function automatic digits_t split_digits(input logic [ValueW-1:0] v);
        digits_t         d;
        logic [15:0]     prod_h;
        logic [ValueW-1:0] rem_h;
        logic [14:0]     prod_t;
        logic [6:0]      rem7;
        prod_h = 16'(v) * 16'd41;
        d.hundreds = prod_h[15:12];
        rem_h = v - 10'(d.hundreds) * 10'd100;
        rem7 = rem_h[6:0];
        prod_t = 15'(rem7) * 15'd205;
        d.tens = prod_t[14:11];
        d.ones = 4'(rem7 - 7'(d.tens) * 7'd10);
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/seven_segment_scan_driver.sv
// Three-digit multiplexed seven-segment scan driver.
//
// Input channel (in_valid/in_ready, ms_tick): one transfer per clock tick
// event; ms_tick = 1 counts a millisecond, 0 passes no time.
// Output channel (out_valid/out_ready): exactly one result per input
// transfer, in order: digit_enable, segments_n (active low), refreshed.
// The scan advances one step once the tick count exceeds scan_period.
// Latency: if the buffer is empty, a result is valid the cycle after it.
// Throughput: one transfer per cycle; the scan state updates in the
// transfer cycle, and a two-entry result buffer decouples the sides.
// When the receiver stalls, results queue in the buffer; in_ready drops
// only when both entries are full and returns once one is taken.
// Reset (rst_n low, asynchronous) clears the count, phases, held drive
// and buffer, and loads mode 0, value 0, period 5.
// APB registers: 0x0 display_mode, 0x4 display_value, 0x8 scan_period.
// Depends on sssd_pkg and sssd_core.
`default_nettype none

module seven_segment_scan_driver
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        ms_tick,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       digit_enable,
    output logic [6:0]       segments_n,
    output logic             refreshed
);

    sssd_pkg::cfg_t    cfg_reg;
    sssd_pkg::result_t step_result;
    sssd_pkg::result_t slot_reg [2];
    sssd_pkg::result_t head;
    logic [1:0]        count_reg;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic              push;
    logic              pop;
    logic              cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_mode <= 1'b0;
            cfg_reg.display_value <= '0;
            cfg_reg.scan_period <= sssd_pkg::PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                sssd_pkg::REG_MODE:   cfg_reg.display_mode <= pwdata[0];
                sssd_pkg::REG_VALUE:  cfg_reg.display_value <= pwdata[sssd_pkg::ValueW-1:0];
                sssd_pkg::REG_PERIOD: cfg_reg.scan_period <= pwdata[sssd_pkg::CountW-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sssd_pkg::REG_MODE:   prdata = 32'(cfg_reg.display_mode);
            sssd_pkg::REG_VALUE:  prdata = 32'(cfg_reg.display_value);
            sssd_pkg::REG_PERIOD: prdata = 32'(cfg_reg.scan_period);
            default:              prdata = '0;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    sssd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (push),
        .ms_tick (ms_tick),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head = slot_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign digit_enable = head.digit_enable;
    assign segments_n = head.segments_n;
    assign refreshed = head.refreshed;

endmodule

`default_nettype wire

>>> design/sssd_core.sv
// Scan state of the seven-segment driver: tick counter, number and word phases
// and the held drive. Depends on sssd_pkg.
`default_nettype none

module sssd_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_en,
    input  wire logic             ms_tick,
    input  wire sssd_pkg::cfg_t   cfg,
    output sssd_pkg::result_t     result
);

    logic [sssd_pkg::CountW-1:0]  elapsed_reg, elapsed_next;
    sssd_pkg::number_phase_t      number_phase_reg, number_phase_next;
    logic                         word_phase_reg, word_phase_next;
    logic [sssd_pkg::EnableW-1:0] held_enable_reg, held_enable_next;
    logic [sssd_pkg::SegW-1:0]    held_segments_reg, held_segments_next;

    logic [sssd_pkg::CountW-1:0]  count_inc;
    logic                         fire;
    logic [sssd_pkg::ValueW-1:0]  value_sat;
    sssd_pkg::digits_t            digits;
    logic [sssd_pkg::EnableW-1:0] sel;
    logic [3:0]                   glyph;

    assign count_inc = elapsed_reg +
        sssd_pkg::CountW'(ms_tick && (elapsed_reg != sssd_pkg::COUNT_MAX));
    assign fire = count_inc > cfg.scan_period;

    assign value_sat = (cfg.display_value > sssd_pkg::VALUE_MAX) ?
        sssd_pkg::VALUE_MAX : cfg.display_value;
    assign digits = sssd_pkg::split_digits(value_sat);

    always_comb
    begin
        sel = sssd_pkg::SEL_NONE;
        glyph = 4'd0;
        number_phase_next = number_phase_reg;
        word_phase_next = word_phase_reg;
        if (cfg.display_mode)
        begin
            if (!word_phase_reg)
            begin
                sel = sssd_pkg::SEL_LEFT;
                glyph = (cfg.display_value != '0) ? sssd_pkg::GLYPH_H : sssd_pkg::GLYPH_L;
            end
            else
            begin
                sel = sssd_pkg::SEL_MID;
                glyph = (cfg.display_value != '0) ? sssd_pkg::GLYPH_I : sssd_pkg::GLYPH_O;
            end
            word_phase_next = !word_phase_reg;
        end
        else
        begin
            case (number_phase_reg)
                sssd_pkg::PH_TENS:
                begin
                    if (digits.hundreds != 4'd0 || digits.tens != 4'd0)
                    begin
                        sel = sssd_pkg::SEL_MID;
                        glyph = digits.tens;
                    end
                    number_phase_next = sssd_pkg::PH_ONES;
                end
                sssd_pkg::PH_ONES:
                begin
                    sel = sssd_pkg::SEL_RIGHT;
                    glyph = digits.ones;
                    number_phase_next = sssd_pkg::PH_HUNDREDS;
                end
                default:
                begin
                    // phase three behaves as the hundreds step
                    if (digits.hundreds != 4'd0)
                    begin
                        sel = sssd_pkg::SEL_LEFT;
                        glyph = digits.hundreds;
                    end
                    number_phase_next = sssd_pkg::PH_TENS;
                end
            endcase
        end
    end

    always_comb
    begin
        if (fire)
        begin
            elapsed_next = '0;
            held_enable_next = sel;
            held_segments_next = ~sssd_pkg::glyph_bits(glyph);
        end
        else
        begin
            elapsed_next = count_inc;
            held_enable_next = held_enable_reg;
            held_segments_next = held_segments_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            number_phase_reg <= sssd_pkg::PH_HUNDREDS;
            word_phase_reg <= 1'b0;
            held_enable_reg <= '0;
            held_segments_reg <= '0;
        end
        else if (step_en)
        begin
            elapsed_reg <= elapsed_next;
            held_enable_reg <= held_enable_next;
            held_segments_reg <= held_segments_next;
            if (fire)
            begin
                number_phase_reg <= number_phase_next;
                word_phase_reg <= word_phase_next;
            end
        end
    end

    assign result.digit_enable = held_enable_next;
    assign result.segments_n = held_segments_next;
    assign result.refreshed = fire;

endmodule

`default_nettype wire

>>> test/sssd_checker.sv
// Checker for the seven-segment scan driver: watches the register port and both channels,
// predicts each drive result, and compares it field by field with what the block returns.
// Depends on sssd_pkg.

module sssd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        ms_tick,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  digit_enable,
    input  logic [6:0]  segments_n,
    input  logic        refreshed,
    output int          error_count,
    output int          pending,
    output int          transfers_seen,
    output int          steps_seen
);

    localparam logic WORD_FIRST = 1'b0;
    localparam logic WORD_SECOND = 1'b1;
    localparam int DIGIT_ZERO = 0;

    // lit segments per glyph, index 0..9 digits then H, L, I, O
    localparam logic [13:0][sssd_pkg::SegW-1:0] LIT_SEGS = {
        7'h5C, 7'h30, 7'h38, 7'h76, 7'h6F, 7'h7F, 7'h27,
        7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    sssd_pkg::cfg_t                 cfg;
    logic [sssd_pkg::CountW-1:0]    elapsed;
    sssd_pkg::number_phase_t        num_phase;
    logic                           word_phase;
    logic [sssd_pkg::EnableW-1:0]   held_en;
    logic [sssd_pkg::SegW-1:0]      held_seg;
    sssd_pkg::result_t              drive_q[$];
    int                             errors = 0;

    assign error_count = errors;

    function automatic void show_glyph(input logic [sssd_pkg::EnableW-1:0] sel,
                                       input int code);
        held_en = sel;
        held_seg = ~LIT_SEGS[code];
    endfunction

    function automatic sssd_pkg::result_t advance_scan(input logic tick);
        sssd_pkg::result_t r;
        int      v;
        int      hun;
        int      ten;
        r.refreshed = 1'b0;
        if (tick && elapsed != sssd_pkg::COUNT_MAX)
            elapsed = elapsed + 1'b1;
        if (elapsed > cfg.scan_period)
        begin
            elapsed = '0;
            r.refreshed = 1'b1;
            if (!cfg.display_mode)
            begin
                v = (cfg.display_value > sssd_pkg::VALUE_MAX) ?
                    int'(sssd_pkg::VALUE_MAX) : int'(cfg.display_value);
                hun = v / 100;
                ten = (v % 100) / 10;
                case (num_phase)
                    sssd_pkg::PH_TENS:
                    begin
                        if (hun == 0 && ten == 0)
                            show_glyph(sssd_pkg::SEL_NONE, DIGIT_ZERO);
                        else
                            show_glyph(sssd_pkg::SEL_MID, ten);
                        num_phase = sssd_pkg::PH_ONES;
                    end
                    sssd_pkg::PH_ONES:
                    begin
                        show_glyph(sssd_pkg::SEL_RIGHT, v % 10);
                        num_phase = sssd_pkg::PH_HUNDREDS;
                    end
                    default:
                    begin
                        if (hun == 0)
                            show_glyph(sssd_pkg::SEL_NONE, DIGIT_ZERO);
                        else
                            show_glyph(sssd_pkg::SEL_LEFT, hun);
                        num_phase = sssd_pkg::PH_TENS;
                    end
                endcase
            end
            else if (word_phase == WORD_FIRST)
            begin
                show_glyph(sssd_pkg::SEL_LEFT, (cfg.display_value != 0) ?
                           int'(sssd_pkg::GLYPH_H) : int'(sssd_pkg::GLYPH_L));
                word_phase = WORD_SECOND;
            end
            else
            begin
                show_glyph(sssd_pkg::SEL_MID, (cfg.display_value != 0) ?
                           int'(sssd_pkg::GLYPH_I) : int'(sssd_pkg::GLYPH_O));
                word_phase = WORD_FIRST;
            end
        end
        r.digit_enable = held_en;
        r.segments_n = held_seg;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sssd_pkg::result_t want;
        if (!rst_n)
        begin
            cfg.display_mode = 1'b0;
            cfg.display_value = '0;
            cfg.scan_period = sssd_pkg::PERIOD_RESET;
            elapsed = '0;
            num_phase = sssd_pkg::PH_HUNDREDS;
            word_phase = WORD_FIRST;
            held_en = sssd_pkg::SEL_NONE;
            held_seg = '0;
            drive_q.delete();
            pending <= 0;
            transfers_seen <= 0;
            steps_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    sssd_pkg::REG_MODE:   cfg.display_mode = pwdata[0];
                    sssd_pkg::REG_VALUE:  cfg.display_value = pwdata[sssd_pkg::ValueW-1:0];
                    sssd_pkg::REG_PERIOD: cfg.scan_period = pwdata[sssd_pkg::CountW-1:0];
                    default:              ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                drive_q.push_back(advance_scan(ms_tick));
                transfers_seen <= transfers_seen + 1;
            end
            if (out_valid && out_ready)
            begin
                if (drive_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] result transfer with nothing pending: %0h %0h %0h",
                                 $time, digit_enable, segments_n, refreshed);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (digit_enable !== want.digit_enable)
                        note_mismatch("digit_enable", want.digit_enable, digit_enable);
                    if (segments_n !== want.segments_n)
                        note_mismatch("segments_n", want.segments_n, segments_n);
                    if (refreshed !== want.refreshed)
                        note_mismatch("refreshed", want.refreshed, refreshed);
                    if (want.refreshed)
                        steps_seen <= steps_seen + 1;
                end
            end
            pending <= drive_q.size();
        end
    end

endmodule

>>> test/tb_seven_segment_scan_driver.sv
// Testbench top for the seven-segment scan driver: clock, reset, register writes,
// tick stimulus with random idling, watchdog and verdict.
// Depends on sssd_pkg, seven_segment_scan_driver and sssd_checker.

module tb_seven_segment_scan_driver;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_PCT = 29;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 98;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        ms_tick = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  digit_enable;
    logic [6:0]  segments_n;
    logic        refreshed;
    logic        steady = 1'b0;

    int error_count;
    int pending;
    int transfers_seen;
    int steps_seen;
    int quiet_cycles = 0;
    int writes_made = 0;

    always #5 clk = ~clk;

    seven_segment_scan_driver dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .ms_tick(ms_tick),
        .out_valid(out_valid), .out_ready(out_ready),
        .digit_enable(digit_enable), .segments_n(segments_n), .refreshed(refreshed)
    );

    sssd_checker drive_check (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready), .ms_tick(ms_tick),
        .out_valid(out_valid), .out_ready(out_ready),
        .digit_enable(digit_enable), .segments_n(segments_n), .refreshed(refreshed),
        .error_count(error_count), .pending(pending),
        .transfers_seen(transfers_seen), .steps_seen(steps_seen)
    );

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles, %0d results pending",
                     STALL_LIMIT, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_tick(input logic tick);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            ms_tick <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ms_tick <= tick;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic run_ticks(input int count, input int tick_pct);
        repeat (count)
            send_tick($urandom_range(0, 99) < tick_pct);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // setup cycle, access cycle, then psel and penable drop back low
    task automatic program_reg(input logic [1:0] idx, input logic [31:0] data);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        writes_made++;
    endtask

    // junk above the register width must be dropped
    function automatic logic [31:0] pad_bits(input logic [31:0] val, input int w);
        return ($urandom << w) | val;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = $urandom_range(1, 9);
            2: v = $urandom_range(10, 99);
            3: v = $urandom_range(100, 999);
            4: v = 100 * $urandom_range(1, 9) + $urandom_range(0, 9);
            default: v = $urandom_range(1000, 1023);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] period;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: blank hundreds step after the sixth tick
        repeat (6) send_tick(1'b1);
        program_reg(sssd_pkg::REG_PERIOD, 32'd0);
        program_reg(sssd_pkg::REG_VALUE, 32'd105);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        program_reg(sssd_pkg::REG_VALUE, 32'd40);
        repeat (3) send_tick(1'b1);
        program_reg(sssd_pkg::REG_VALUE, 32'd1023);
        repeat (3) send_tick(1'b1);
        program_reg(sssd_pkg::REG_VALUE, 32'd0);
        repeat (3) send_tick(1'b1);
        program_reg(sssd_pkg::REG_MODE, 32'd1);
        repeat (2) send_tick(1'b1);
        program_reg(sssd_pkg::REG_VALUE, 32'd999);
        send_tick(1'b1);
        program_reg(sssd_pkg::REG_PERIOD, 32'd65534);
        repeat (3) send_tick(1'b1);
        program_reg(REG_UNUSED, $urandom);
        // period dropped under the count: steps without a tick
        program_reg(sssd_pkg::REG_PERIOD, 32'd1);
        send_tick(1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady <= (ph == 4 || ph == 5);
            if (ph == 0)
                period = 0;
            else if (ph == 1)
                period = 65534;
            else if ($urandom_range(0, 3) == 0)
                period = $urandom_range(5, 30);
            else
                period = $urandom_range(0, 4);
            program_reg(sssd_pkg::REG_MODE, pad_bits($urandom_range(0, 1), 1));
            program_reg(sssd_pkg::REG_VALUE, pad_bits(pick_value(), sssd_pkg::ValueW));
            program_reg(sssd_pkg::REG_PERIOD, pad_bits(period, sssd_pkg::CountW));
            run_ticks(PHASE_ITEMS, (ph % 3 == 2) ? 50 : 85);
            if (ph == 1 || $urandom_range(0, 2) == 0)
            begin
                program_reg(sssd_pkg::REG_PERIOD, $urandom_range(0, 2));
                send_tick(1'b0);
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Ran %0d tick transfers across %0d register writes; %0d advanced the scan.",
                 transfers_seen, writes_made, steps_seen);
        $display("Both modes, periods 0 to 65534, blanked digits and saturated values covered.");
        if (error_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
design/sssd_pkg.sv
design/sssd_core.sv
design/seven_segment_scan_driver.sv
test/sssd_checker.sv
test/tb_seven_segment_scan_driver.sv
